FILE: hw/rtl/adsr_pkg.sv
package adsr_pkg;

  localparam int unsigned FRAME_BITS_DEF = 48;
  localparam int unsigned TIME_BITS_DEF  = 24;

  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned QUOT_BITS = 15;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // The serial multiplier takes a signed 17-bit operand so that an unsigned
  // Q1.15 level of exactly 1.0 and a signed amplitude both fit.
  localparam int unsigned MUL_A_W = LEVEL_W + 1;
  localparam int unsigned MUL_B_W = LEVEL_W;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [LEVEL_W-1:0] ONE_Q15 = 16'h8000;

  localparam int unsigned ATTACK_RST   = 441;
  localparam int unsigned DECAY_RST    = 4410;
  localparam int unsigned DURATION_RST = 22050;
  localparam int unsigned RELEASE_RST  = 4410;
  localparam logic [LEVEL_W-1:0] SUSTAIN_RST = 16'd16384;
  localparam logic [LEVEL_W-1:0] XFADE_RST   = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK,
    CFG_DECAY,
    CFG_SUSTAIN,
    CFG_DURATION,
    CFG_RELEASE,
    CFG_XFADE
  } adsr_cfg_e;

  typedef enum logic [OP_W-1:0] {
    OP_TICK,
    OP_RETRIG,
    OP_RETRIG_AMP
  } adsr_op_e;

  typedef enum logic [2:0] {
    RG_OUT,
    RG_ATTACK,
    RG_DECAY,
    RG_SUSTAIN,
    RG_RELEASE
  } adsr_region_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUB,
    ST_REGION,
    ST_DIV,
    ST_SHAPE,
    ST_ENV_MUL,
    ST_ENV_FIX,
    ST_AMP_MUL,
    ST_LEVEL,
    ST_BLEND_MUL,
    ST_MIX,
    ST_DONE
  } adsr_state_e;

endpackage

FILE: hw/rtl/adsr_if.sv
interface adsr_in_if #(
  parameter int unsigned FRAME_BITS = adsr_pkg::FRAME_BITS_DEF
);
  import adsr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            opcode;
  logic [FRAME_BITS-1:0]      tick_frame;
  logic [FRAME_BITS-1:0]      start_frame;
  logic signed [LEVEL_W-1:0]  new_amplitude;

  modport source (
    output valid, opcode, tick_frame, start_frame, new_amplitude,
    input  ready
  );

  modport sink (
    input  valid, opcode, tick_frame, start_frame, new_amplitude,
    output ready
  );
endinterface

interface adsr_out_if;
  import adsr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [LEVEL_W-1:0]  level;
  logic                       in_window;
  logic                       fading_now;

  modport source (
    output valid, level, in_window, fading_now,
    input  ready
  );

  modport sink (
    input  valid, level, in_window, fading_now,
    output ready
  );
endinterface

FILE: hw/rtl/adsr_envelope_crossfade.sv
// A tick runs through subtraction, region selection and the bit-serial divider,
// then a serial envelope multiplication when it falls in a decay or release ramp,
// the amplitude multiplication and, while a crossfade runs, a blend multiplication.
// One item at a time: the next transfer is taken in the cycle after the result
// is loaded.
// Reset clears the state and the output valid flag and loads the register defaults.
module adsr_envelope_crossfade #(
  parameter int unsigned FRAME_BITS = adsr_pkg::FRAME_BITS_DEF,
  parameter int unsigned TIME_BITS  = adsr_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TIME_BITS-1:0]           cfg_wdata_i,
  adsr_in_if.sink                        item_i,
  adsr_out_if.source                     result_o
);
  import adsr_pkg::*;

  localparam int unsigned CMP_W = FRAME_BITS + 1;

  // Configuration
  logic [TIME_BITS-1:0] attack_q, decay_q, dur_q, rel_q;
  logic [LEVEL_W-1:0]   sustain_q, xfade_q;
  logic [LEVEL_W-1:0]   sus_clamp;
  logic [LEVEL_W-1:0]   xfade_len;

  // Voice state
  logic [FRAME_BITS-1:0]     start_q;
  logic signed [LEVEL_W-1:0] amp_q, last_q, hold_q;
  logic                      fading_q;
  logic [LEVEL_W-1:0]        fade_cnt_q;

  // Sequencer and working registers
  adsr_state_e               state_q, state_d;
  adsr_region_e              region_q, region_d;
  logic [FRAME_BITS-1:0]     frame_q;
  logic [FRAME_BITS:0]       elapsed_q;
  logic [TIME_BITS:0]        ad_sum_q, dr_sum_q;
  logic                      win_q, win_d;
  logic                      sat_q;
  logic [LEVEL_W-1:0]        f_q;
  logic signed [LEVEL_W-1:0] res_q;

  // Output register
  logic                      out_valid_q;
  logic signed [LEVEL_W-1:0] out_level_q;
  logic                      out_win_q, out_fade_q;

  // Datapath wires
  logic                      in_xfer, tick_xfer, retrig_xfer;
  logic                      out_load;
  logic [CMP_W-1:0]          el_x;
  logic [TIME_BITS-1:0]      el_t;
  logic [TIME_BITS-1:0]      env_num, env_den;
  logic                      div_start;
  logic                      div_env_done, div_fade_done;
  logic [QUOT_BITS-1:0]      div_env_q, div_fade_q;
  logic [LEVEL_W-1:0]        qx, one_minus_q;
  logic [LEVEL_W-1:0]        env_d;
  logic                      ramp_mul;

  logic                      mul_a_start, mul_b_start;
  logic signed [MUL_A_W-1:0] mul_a_a, mul_b_a;
  logic [MUL_B_W-1:0]        mul_a_b, mul_b_b;
  logic                      mul_a_done, mul_b_done;
  logic signed [MUL_P_W-1:0] mul_a_p, mul_b_p;
  logic signed [LEVEL_W-1:0] v_d;
  logic [MUL_P_W:0]          mix_sum;

  assign in_xfer     = item_i.valid && item_i.ready;
  assign tick_xfer   = in_xfer && (item_i.opcode == OP_TICK);
  assign retrig_xfer = in_xfer &&
                       ((item_i.opcode == OP_RETRIG) || (item_i.opcode == OP_RETRIG_AMP));

  assign item_i.ready        = (state_q == ST_IDLE);
  assign result_o.valid      = out_valid_q;
  assign result_o.level      = out_level_q;
  assign result_o.in_window  = out_win_q;
  assign result_o.fading_now = out_fade_q;

  assign sus_clamp = (sustain_q > ONE_Q15) ? ONE_Q15 : sustain_q;
  assign xfade_len = (xfade_q == '0) ? LEVEL_W'(1) : xfade_q;

  // Window and ramp selection, evaluated in the region step.
  always_comb begin
    el_x     = {1'b0, elapsed_q[FRAME_BITS-1:0]};
    el_t     = elapsed_q[TIME_BITS-1:0];
    win_d    = !elapsed_q[FRAME_BITS] && (el_x < CMP_W'(dr_sum_q));
    region_d = RG_OUT;
    if (win_d) begin
      if (el_x < CMP_W'(attack_q)) begin
        region_d = RG_ATTACK;
      end else if (el_x < CMP_W'(ad_sum_q)) begin
        region_d = RG_DECAY;
      end else if (el_x < CMP_W'(dur_q)) begin
        region_d = RG_SUSTAIN;
      end else begin
        region_d = RG_RELEASE;
      end
    end
    case (region_d)
      RG_DECAY: begin
        env_num = el_t - attack_q;
        env_den = decay_q;
      end
      RG_RELEASE: begin
        env_num = el_t - dur_q;
        env_den = rel_q;
      end
      default: begin
        env_num = el_t;
        env_den = attack_q;
      end
    endcase
  end

  assign div_start = (state_q == ST_REGION);

  adsr_ser_div #(
    .W(TIME_BITS)
  ) u_div_env (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (env_num),
    .den_i   (env_den),
    .done_o  (div_env_done),
    .quot_o  (div_env_q)
  );

  adsr_ser_div #(
    .W(LEVEL_W)
  ) u_div_fade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (fade_cnt_q),
    .den_i   (xfade_len),
    .done_o  (div_fade_done),
    .quot_o  (div_fade_q)
  );

  // Unsigned envelope level in Q1.15.
  always_comb begin
    qx          = {1'b0, div_env_q};
    one_minus_q = ONE_Q15 - qx;
    ramp_mul    = (region_q == RG_DECAY) || (region_q == RG_RELEASE);
    env_d       = '0;
    if (state_q == ST_ENV_FIX) begin
      if (region_q == RG_DECAY) begin
        env_d = mul_a_p[30:15] + ONE_Q15 - qx;
      end else begin
        env_d = mul_a_p[30:15];
      end
    end else begin
      case (region_q)
        RG_ATTACK:  env_d = qx;
        RG_SUSTAIN: env_d = sus_clamp;
        default:    env_d = '0;
      endcase
    end
  end

  assign v_d     = $signed(mul_a_p[30:15]);
  assign mix_sum = {mul_a_p[MUL_P_W-1], mul_a_p} + {mul_b_p[MUL_P_W-1], mul_b_p};

  adsr_ser_mul #(
    .A_W(MUL_A_W),
    .B_W(MUL_B_W)
  ) u_mul_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_a_start),
    .a_i     (mul_a_a),
    .b_i     (mul_a_b),
    .done_o  (mul_a_done),
    .prod_o  (mul_a_p)
  );

  adsr_ser_mul #(
    .A_W(MUL_A_W),
    .B_W(MUL_B_W)
  ) u_mul_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_b_start),
    .a_i     (mul_b_a),
    .b_i     (mul_b_b),
    .done_o  (mul_b_done),
    .prod_o  (mul_b_p)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (tick_xfer) state_d = ST_SUB;
      ST_SUB:       state_d = ST_REGION;
      ST_REGION:    state_d = ST_DIV;
      ST_DIV:       if (div_env_done) state_d = ST_SHAPE;
      ST_SHAPE:     state_d = ramp_mul ? ST_ENV_MUL : ST_AMP_MUL;
      ST_ENV_MUL:   if (mul_a_done) state_d = ST_ENV_FIX;
      ST_ENV_FIX:   state_d = ST_AMP_MUL;
      ST_AMP_MUL:   if (mul_a_done) state_d = ST_LEVEL;
      ST_LEVEL:     state_d = fading_q ? ST_BLEND_MUL : ST_DONE;
      ST_BLEND_MUL: if (mul_a_done) state_d = ST_MIX;
      ST_MIX:       state_d = ST_DONE;
      ST_DONE:      if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier starts and operands, output load.
  always_comb begin
    mul_a_start = 1'b0;
    mul_a_a     = '0;
    mul_a_b     = '0;
    mul_b_start = 1'b0;
    mul_b_a     = '0;
    mul_b_b     = '0;
    out_load    = 1'b0;
    case (state_q)
      ST_SHAPE: begin
        mul_a_start = 1'b1;
        if (ramp_mul) begin
          mul_a_a = $signed({1'b0, sus_clamp});
          mul_a_b = (region_q == RG_DECAY) ? qx : one_minus_q;
        end else begin
          mul_a_a = $signed({amp_q[LEVEL_W-1], amp_q});
          mul_a_b = env_d;
        end
      end
      ST_ENV_FIX: begin
        mul_a_start = 1'b1;
        mul_a_a     = $signed({amp_q[LEVEL_W-1], amp_q});
        mul_a_b     = env_d;
      end
      ST_LEVEL: begin
        mul_a_start = fading_q;
        mul_a_a     = $signed({v_d[LEVEL_W-1], v_d});
        mul_a_b     = f_q;
        mul_b_start = fading_q;
        mul_b_a     = $signed({hold_q[LEVEL_W-1], hold_q});
        mul_b_b     = ONE_Q15 - f_q;
      end
      ST_DONE: begin
        out_load = !out_valid_q || result_o.ready;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= TIME_BITS'(ATTACK_RST);
      decay_q   <= TIME_BITS'(DECAY_RST);
      sustain_q <= SUSTAIN_RST;
      dur_q     <= TIME_BITS'(DURATION_RST);
      rel_q     <= TIME_BITS'(RELEASE_RST);
      xfade_q   <= XFADE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ATTACK:   attack_q  <= cfg_wdata_i;
        CFG_DECAY:    decay_q   <= cfg_wdata_i;
        CFG_SUSTAIN:  sustain_q <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_DURATION: dur_q     <= cfg_wdata_i;
        CFG_RELEASE:  rel_q     <= cfg_wdata_i;
        CFG_XFADE:    xfade_q   <= cfg_wdata_i[LEVEL_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= '0;
      amp_q       <= '0;
      last_q      <= '0;
      hold_q      <= '0;
      fading_q    <= 1'b0;
      fade_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (retrig_xfer) begin
        fading_q   <= 1'b1;
        fade_cnt_q <= '0;
        hold_q     <= last_q;
        start_q    <= item_i.start_frame;
        if (item_i.opcode == OP_RETRIG_AMP) begin
          amp_q <= item_i.new_amplitude;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        last_q      <= res_q;
        if (fading_q) begin
          if (sat_q) begin
            fading_q <= 1'b0;
          end else begin
            fade_cnt_q <= fade_cnt_q + LEVEL_W'(1);
          end
        end
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_xfer) begin
      frame_q <= item_i.tick_frame;
    end
    if (state_q == ST_SUB) begin
      elapsed_q <= {1'b0, frame_q} - {1'b0, start_q};
      ad_sum_q  <= {1'b0, attack_q} + {1'b0, decay_q};
      dr_sum_q  <= {1'b0, dur_q} + {1'b0, rel_q};
    end
    if (state_q == ST_REGION) begin
      region_q <= region_d;
      win_q    <= win_d;
      sat_q    <= (fade_cnt_q >= xfade_len);
    end
    if (state_q == ST_SHAPE) begin
      // A count at or past the crossfade length gives a fraction of one.
      f_q <= sat_q ? ONE_Q15 : {1'b0, div_fade_q};
    end
    if (state_q == ST_LEVEL) begin
      res_q <= v_d;
    end
    if (state_q == ST_MIX) begin
      res_q <= $signed(mix_sum[30:15]);
    end
    if (out_load) begin
      out_level_q <= res_q;
      out_win_q   <= win_q;
      out_fade_q  <= fading_q;
    end
  end

  a_out_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result became valid outside the done step");

  a_div_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_env_done == div_fade_done)
    else $error("envelope and fade dividers out of step");

  a_mul_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_b_done |-> (mul_a_done && state_q == ST_BLEND_MUL))
    else $error("blend multipliers out of step");

  a_silent_outside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.in_window && !result_o.fading_now)
      |-> (result_o.level == '0))
    else $error("non-zero level outside the window without a crossfade");

endmodule

FILE: hw/rtl/adsr_ser_div.sv
module adsr_ser_div #(
  parameter int unsigned W = adsr_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [W-1:0]                   num_i,
  input  logic [W-1:0]                   den_i,
  output logic                           done_o,
  output logic [adsr_pkg::QUOT_BITS-1:0] quot_o
);
  import adsr_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUOT_BITS);

  logic [W-1:0]         rem_q, rem_d;
  logic [W-1:0]         den_q;
  logic [QUOT_BITS-1:0] quot_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;
  logic [W:0]           rem2;
  logic [W:0]           diff;
  logic                 ge;

  // One quotient bit per cycle by restoring division. The caller must keep the
  // numerator below the divisor (not enforced here) for a W-bit remainder.
  always_comb begin
    rem2  = {rem_q, 1'b0};
    diff  = rem2 - {1'b0, den_q};
    ge    = (rem2 >= {1'b0, den_q});
    rem_d = ge ? diff[W-1:0] : rem2[W-1:0];
  end

  assign done_o = busy_q && (cnt_q == CNT_W'(QUOT_BITS - 1));
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      busy_q <= !done_o;
      cnt_q  <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[QUOT_BITS-2:0], ge};
    end
  end

endmodule

FILE: hw/rtl/adsr_ser_mul.sv
module adsr_ser_mul #(
  parameter int unsigned A_W = adsr_pkg::MUL_A_W,
  parameter int unsigned B_W = adsr_pkg::MUL_B_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [A_W-1:0]       a_i,
  input  logic [B_W-1:0]              b_i,
  output logic                        done_o,
  output logic signed [A_W+B_W-1:0]   prod_o
);
  import adsr_pkg::*;

  localparam int unsigned CNT_W = $clog2(B_W);

  logic signed [A_W-1:0] a_q;
  logic signed [A_W:0]   hi_q, hi_d;
  logic [B_W-1:0]        lo_q, lo_d;
  logic signed [A_W:0]   addend;
  logic signed [A_W:0]   sum;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;

  // Shift-add, least significant multiplier bit first. The multiplier
  // shifts out of lo while the low product bits shift in behind it.
  always_comb begin
    addend = lo_q[0] ? $signed({a_q[A_W-1], a_q}) : '0;
    sum    = hi_q + addend;
    hi_d   = sum >>> 1;
    lo_d   = {sum[0], lo_q[B_W-1:1]};
  end

  assign done_o = busy_q && (cnt_q == CNT_W'(B_W - 1));
  assign prod_o = $signed({hi_q[A_W-1:0], lo_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      busy_q <= !done_o;
      cnt_q  <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

endmodule

FILE: tb/sv/adsr_envelope_crossfade_tb.sv
`timescale 1ns / 1ps

module adsr_envelope_crossfade_tb;
  import adsr_pkg::*;

  localparam int unsigned PHASES          = 8;
  localparam int unsigned PHASE_ITEMS     = 185;
  localparam int unsigned SETTLE_CYCLES   = 100;
  localparam int unsigned IDLE_LIMIT      = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam longint      FULL_SCALE      = 32768;

  localparam logic [OP_W-1:0]      OP_RESERVED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [47:0]               tick_frame;
    logic [47:0]               start_frame;
    logic signed [LEVEL_W-1:0] amplitude;
  } env_item_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic                      in_window;
    logic                      fading_now;
  } env_sample_t;

  typedef enum int unsigned {RX_STEADY, RX_COIN, RX_SPARSE} rx_pattern_e;

  class envelope_scoreboard;
    int unsigned               attack_len, decay_len, sustain, duration_len;
    int unsigned               release_len, xfade_len;
    logic [47:0]               start_frame;
    logic signed [LEVEL_W-1:0] gain, last_level, hold_level;
    bit                        fading;
    int unsigned               fade_count;
    env_sample_t               expected_samples[$];
    int unsigned               errors;

    function new();
      attack_len   = ATTACK_RST;
      decay_len    = DECAY_RST;
      sustain      = SUSTAIN_RST;
      duration_len = DURATION_RST;
      release_len  = RELEASE_RST;
      xfade_len    = XFADE_RST;
      start_frame  = '0;
      gain         = '0;
      last_level   = '0;
      hold_level   = '0;
      fading       = 1'b0;
      fade_count   = 0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] data);
      case (idx)
        CFG_ATTACK:   attack_len   = data;
        CFG_DECAY:    decay_len    = data;
        CFG_SUSTAIN:  sustain      = data[15:0];
        CFG_DURATION: duration_len = data;
        CFG_RELEASE:  release_len  = data;
        CFG_XFADE:    xfade_len    = data[15:0];
        default: ;
      endcase
    endfunction

    function void take_item(env_item_t it);
      longint unsigned elapsed, env, ramp, lvl;
      longint          v, frac, span;
      env_sample_t     smp;
      if (it.op == OP_RETRIG || it.op == OP_RETRIG_AMP) begin
        fading      = 1'b1;
        fade_count  = 0;
        hold_level  = last_level;
        start_frame = it.start_frame;
        if (it.op == OP_RETRIG_AMP) gain = it.amplitude;
        return;
      end
      if (it.op != OP_TICK) return;

      lvl = (sustain > FULL_SCALE) ? FULL_SCALE : sustain;
      env = 0;
      smp.in_window  = 1'b0;
      smp.fading_now = fading;
      if (it.tick_frame >= start_frame) begin
        elapsed = it.tick_frame - start_frame;
        if (elapsed < duration_len + release_len) begin
          smp.in_window = 1'b1;
          if (elapsed < attack_len) begin
            env = (elapsed << QUOT_BITS) / attack_len;
          end else if (elapsed < attack_len + decay_len) begin
            ramp = ((elapsed - attack_len) << QUOT_BITS) / decay_len;
            env  = ((ramp * lvl) >> QUOT_BITS) + FULL_SCALE - ramp;
          end else if (elapsed < duration_len) begin
            env = lvl;
          end else begin
            ramp = ((elapsed - duration_len) << QUOT_BITS) / release_len;
            env  = ((FULL_SCALE - ramp) * lvl) >> QUOT_BITS;
          end
        end
      end
      v = (longint'(env) * longint'(gain)) >>> QUOT_BITS;

      if (fading) begin
        span = (xfade_len == 0) ? 1 : xfade_len;
        frac = (longint'(fade_count) << QUOT_BITS) / span;
        // A crossfade shortened mid-fade can push the fraction past one.
        if (frac > FULL_SCALE) frac = FULL_SCALE;
        v = (v * frac + longint'(hold_level) * (FULL_SCALE - frac)) >>> QUOT_BITS;
        if (fade_count >= span) fading = 1'b0;
        else fade_count++;
      end

      last_level = v[15:0];
      smp.level  = v[15:0];
      expected_samples.insert(expected_samples.size(), smp);
    endfunction

    function void check_sample(env_sample_t got);
      env_sample_t want;
      if (expected_samples.size() == 0) begin
        errors++;
        $display("%0t: sample with nothing pending, expected none, got level %0d",
                 $time, got.level);
        return;
      end
      want = expected_samples.pop_front();
      if (got.level !== want.level) begin
        errors++;
        $display("%0t: level expected %0d got %0d", $time, want.level, got.level);
      end
      if (got.in_window !== want.in_window) begin
        errors++;
        $display("%0t: in_window expected %0b got %0b", $time, want.in_window,
                 got.in_window);
      end
      if (got.fading_now !== want.fading_now) begin
        errors++;
        $display("%0t: fading_now expected %0b got %0b", $time, want.fading_now,
                 got.fading_now);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [23:0]          cfg_wdata_i;

  adsr_in_if  #(.FRAME_BITS(48)) item_if ();
  adsr_out_if                    result_if ();

  adsr_envelope_crossfade #(
    .FRAME_BITS(48),
    .TIME_BITS (24)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  envelope_scoreboard sb = new();

  logic [23:0] setting [6];
  bit          hold_off_req = 1'b0;
  int unsigned quiet_cycles = 0;
  env_item_t   seen_item;
  env_sample_t seen_sample;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    if (rst_ni && item_if.valid && item_if.ready) begin
      seen_item.op          = item_if.opcode;
      seen_item.tick_frame  = item_if.tick_frame;
      seen_item.start_frame = item_if.start_frame;
      seen_item.amplitude   = item_if.new_amplitude;
      sb.take_item(seen_item);
    end
    if (rst_ni && result_if.valid && result_if.ready) begin
      seen_sample.level      = result_if.level;
      seen_sample.in_window  = result_if.in_window;
      seen_sample.fading_now = result_if.fading_now;
      sb.check_sample(seen_sample);
    end
  end

  // Ends the run when neither side has made a transfer for too long.
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : receiver
    rx_pattern_e pattern;
    int unsigned stretch, cyc;
    result_if.ready = 1'b0;
    pattern = RX_STEADY;
    stretch = 0;
    cyc     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        // Hold the output back long enough for the block to stall its input.
        result_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (stretch == 0) begin
          pattern = rx_pattern_e'($urandom_range(0, 2));
          stretch = $urandom_range(20, 200);
        end
        stretch--;
        cyc++;
        case (pattern)
          RX_STEADY: result_if.ready <= 1'b1;
          RX_COIN:   result_if.ready <= 1'($urandom_range(0, 1));
          default:   result_if.ready <= (cyc % 7 == 0);
        endcase
      end
    end
  end

  function automatic env_item_t item_of(logic [OP_W-1:0] op, logic [47:0] tick,
                                        logic [47:0] start, logic [15:0] amp);
    env_item_t it;
    it.op          = op;
    it.tick_frame  = tick;
    it.start_frame = start;
    it.amplitude   = amp;
    return it;
  endfunction

  function automatic logic [47:0] any_frame();
    return {16'($urandom), $urandom};
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input env_item_t it);
    item_if.valid         <= 1'b1;
    item_if.opcode        <= it.op;
    item_if.tick_frame    <= it.tick_frame;
    item_if.start_frame   <= it.start_frame;
    item_if.new_amplitude <= it.amplitude;
    do begin
      @(posedge clk_i);
    end while (item_if.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    item_if.valid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Retriggers give no sample, so the queue tracks only ticks; the block is
  // idle once it is empty, and the settle time covers the longest tick.
  task automatic drain();
    item_if.valid <= 1'b0;
    while (sb.expected_samples.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apply_settings();
    logic [23:0] spare;
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= adsr_cfg_e'(i);
      cfg_wdata_i <= setting[i];
      sb.write_reg(adsr_cfg_e'(i), setting[i]);
      @(negedge clk_i);
    end
    spare = 24'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SPARE_IDX;
    cfg_wdata_i <= spare;
    sb.write_reg(CFG_SPARE_IDX, spare);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    env_item_t   it;
    int unsigned burst_left, pick, span;
    logic [47:0] cur_start;

    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_ATTACK;
    cfg_wdata_i           = '0;
    item_if.valid         = 1'b0;
    item_if.opcode        = OP_TICK;
    item_if.tick_frame    = '0;
    item_if.start_frame   = '0;
    item_if.new_amplitude = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed walk through every region under the reset settings.
    send_item(item_of(OP_TICK, 48'd0, 48'd0, 16'h0000));
    send_item(item_of(OP_RETRIG_AMP, 48'd0, 48'd1000, 16'h7FFF));
    send_item(item_of(OP_TICK, 48'd999, 48'd0, 16'h0000));
    send_item(item_of(OP_TICK, 48'd1000, 48'd0, 16'h0000));
    send_item(item_of(OP_TICK, 48'd1220, 48'd0, 16'h0000));
    send_item(item_of(OP_TICK, 48'd1441, 48'd0, 16'h0000));
    send_item(item_of(OP_TICK, 48'd3000, 48'd0, 16'h0000));
    send_item(item_of(OP_TICK, 48'd12000, 48'd0, 16'h0000));
    send_item(item_of(OP_TICK, 48'd23100, 48'd0, 16'h0000));
    send_item(item_of(OP_TICK, 48'd27459, 48'd0, 16'h0000));
    send_item(item_of(OP_TICK, 48'd27460, 48'd0, 16'h0000));
    send_item(item_of(OP_RESERVED, any_frame(), any_frame(), 16'($urandom)));
    send_item(item_of(OP_RETRIG_AMP, 48'd0, '1, 16'h8000));
    send_item(item_of(OP_TICK, '1, 48'd0, 16'h0000));
    send_item(item_of(OP_TICK, 48'd0, 48'd0, 16'h0000));
    send_item(item_of(OP_RETRIG, '1, 48'd0, 16'h7FFF));
    send_item(item_of(OP_TICK, '1, 48'd0, 16'h0000));
    send_item(item_of(OP_TICK, 48'd441, 48'd0, 16'h0000));
    send_item(item_of(OP_RETRIG_AMP, 48'd0, 48'd5, 16'h4000));
    send_item(item_of(OP_TICK, 48'd4856, 48'd0, 16'h0000));
    send_item(item_of(OP_TICK, 48'd26464, 48'd0, 16'h0000));
    cur_start = 48'd5;
    drain();

    burst_left = 0;
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      // Order: attack, decay, sustain, duration, release, crossfade.
      case (phase)
        0: setting = '{24'd0, 24'd0, 24'd32768, 24'($urandom_range(0, 200)), 24'd0, 24'd0};
        1: setting = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                       24'hFFFFFF};
        2: setting = '{24'($urandom_range(0, 300)), 24'($urandom_range(0, 300)), 24'd0,
                       24'($urandom_range(0, 900)), 24'($urandom_range(0, 400)), 24'd1};
        default: begin
          setting[CFG_ATTACK]   = 24'($urandom_range(0, 300));
          setting[CFG_DECAY]    = 24'($urandom_range(0, 300));
          setting[CFG_SUSTAIN]  = 24'(($urandom_range(0, 9) == 0) ?
                                      $urandom_range(32769, 65535) :
                                      $urandom_range(0, 32768));
          setting[CFG_DURATION] = 24'($urandom_range(0, 900));
          setting[CFG_RELEASE]  = 24'($urandom_range(0, 400));
          setting[CFG_XFADE]    = 24'(($urandom_range(0, 3) == 0) ?
                                      $urandom_range(100, 65535) :
                                      $urandom_range(1, 40));
        end
      endcase
      apply_settings();
      span = setting[CFG_ATTACK] + setting[CFG_DECAY] + setting[CFG_DURATION]
           + setting[CFG_RELEASE] + 20;

      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          pick = $urandom_range(0, 9);
          if (pick >= 5) pause_sender($urandom_range(1, 80));
          else if (pick >= 3) pause_sender($urandom_range(1, 5));
          burst_left = $urandom_range(1, 30);
        end
        if (phase == 3 && n == 60) hold_off_req = 1'b1;

        it = item_of(OP_TICK, any_frame(), any_frame(), 16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          it.op = OP_RESERVED;
        end else if (pick < 9) begin
          it.op = (pick < 5) ? OP_RETRIG : OP_RETRIG_AMP;
          if ($urandom_range(0, 9) != 0) it.start_frame = 48'($urandom_range(0, 1 << 20));
          cur_start = it.start_frame;
        end else begin
          pick = $urandom_range(0, 19);
          // Most ticks land inside or just past the envelope of the last start.
          if (pick == 1) it.tick_frame = cur_start - $urandom_range(1, 50);
          else if (pick > 1) it.tick_frame = cur_start + $urandom_range(0, span);
        end
        send_item(it);
        burst_left--;
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/adsr_pkg.sv
hw/rtl/adsr_if.sv
hw/rtl/adsr_ser_div.sv
hw/rtl/adsr_ser_mul.sv
hw/rtl/adsr_envelope_crossfade.sv
tb/sv/adsr_envelope_crossfade_tb.sv
